// ----- rtl/core/srt_pkg.sv -----
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types and constants for the sorted range table.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int MAX_RANGES = 64;
  localparam int IDX_W      = 32;
  localparam int PTR_W      = $clog2(MAX_RANGES);
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int OP_W       = 3;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 3'd0,
    OP_INSERT  = 3'd1,
    OP_POINT   = 3'd2,
    OP_COVER   = 3'd3,
    OP_OVERLAP = 3'd4,
    OP_READ    = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ORDER   = 3'd1,
    ST_OVERLAP = 3'd2,
    ST_FULL    = 3'd3,
    ST_RANGE   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_PLACE,
    S_RDENT,
    S_DONE
  } state_t;

  typedef struct packed {
    idx_t lo;
    idx_t hi;
  } entry_t;

  typedef struct packed {
    logic   we;
    ptr_t   waddr;
    entry_t wdata;
    ptr_t   raddr;
  } mem_req_t;

  // relations of one stored entry (s, e) against the query (a, b)
  typedef struct packed {
    logic s_lt_a;
    logic s_eq_a;
    logic s_le_b;
    logic e_ge_a;
    logic e_le_b;
    logic e_eq_b;
    logic e_ge_b;
  } cmp_t;

  typedef struct packed {
    logic    hit;
    ptr_t    slot;
    idx_t    entry_start;
    idx_t    entry_end;
    status_t status;
    cnt_t    entries_used;
  } res_t;

endpackage

// ----- rtl/core/srt_in_if.sv -----
// ----------------------------------------------------------------------------
// srt_in_if
// Request channel: operation and operands, valid/ready handshake.
// ----------------------------------------------------------------------------
interface srt_in_if import srt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] op;
  idx_t            range_from;
  idx_t            range_to;
  ptr_t            position;

  modport source (output valid, output op, output range_from, output range_to,
                  output position, input ready);
  modport sink   (input valid, input op, input range_from, input range_to,
                  input position, output ready);
endinterface

// ----- rtl/core/srt_out_if.sv -----
// ----------------------------------------------------------------------------
// srt_out_if
// Response channel: one result per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface srt_out_if import srt_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        hit;
  ptr_t        slot;
  idx_t        entry_start;
  idx_t        entry_end;
  logic [2:0]  status;
  cnt_t        entries_used;

  modport source (output valid, output hit, output slot, output entry_start,
                  output entry_end, output status, output entries_used,
                  input ready);
  modport sink   (input valid, input hit, input slot, input entry_start,
                  input entry_end, input status, input entries_used,
                  output ready);
endinterface

// ----- rtl/core/srt_store.sv -----
// ----------------------------------------------------------------------------
// srt_store
// Range storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srt_store import srt_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rdata
);

  entry_t mem [MAX_RANGES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ----- rtl/core/srt_cmp.sv -----
// ----------------------------------------------------------------------------
// srt_cmp
// Shared compare unit: one stored entry against the query bounds.
// ----------------------------------------------------------------------------
module srt_cmp import srt_pkg::*; (
  input  entry_t ent,
  input  idx_t   a,
  input  idx_t   b,
  output cmp_t   rel
);

  always_comb begin
    rel.s_lt_a = ent.lo < a;
    rel.s_eq_a = ent.lo == a;
    rel.s_le_b = ent.lo <= b;
    rel.e_ge_a = ent.hi >= a;
    rel.e_le_b = ent.hi <= b;
    rel.e_eq_b = ent.hi == b;
    rel.e_ge_b = ent.hi >= b;
  end

endmodule

// ----- rtl/core/srt_seq.sv -----
// ----------------------------------------------------------------------------
// srt_seq
// Sequencer: scans the table one entry per cycle through the compare unit,
// shifts entries up for an insert, and builds the result.
// ----------------------------------------------------------------------------
module srt_seq import srt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,
  srt_in_if.sink      in_ch,
  output mem_req_t    mem,
  input  entry_t      rdata,
  input  cmp_t        rel,
  output idx_t        a_q,
  output idx_t        b_q,
  output logic        res_valid,
  output res_t        res,
  input  logic        out_free
);

  state_t          state;
  state_t          state_next;
  logic [OP_W-1:0] op_q;
  ptr_t            pos_q;
  cnt_t            fill;
  logic            allow_ovl;
  ptr_t            k;
  cnt_t            p;
  logic            dup_f;
  logic            ovl_prev;
  logic            ovl_succ;
  logic            res_hit;
  ptr_t            res_slot;
  idx_t            res_es;
  idx_t            res_ee;
  status_t         res_status;

  logic not_after;
  logic q_hit;
  logic last;
  logic order_bad;
  logic is_full;
  logic pos_bad;
  logic dup;
  logic ovl_fail;
  logic shift_end;

  always_comb begin
    not_after = rel.s_lt_a | (rel.s_eq_a & rel.e_le_b);
    unique case (op_q)
      OP_POINT:   q_hit = (rel.s_lt_a | rel.s_eq_a) & rel.e_ge_a;
      OP_COVER:   q_hit = (rel.s_lt_a | rel.s_eq_a) & rel.e_ge_b;
      OP_OVERLAP: q_hit = rel.s_le_b & rel.e_ge_a;
      default:    q_hit = 1'b0;
    endcase
    last      = (cnt_t'(k) + cnt_t'(1)) == fill;
    order_bad = a_q > b_q;
    is_full   = fill == cnt_t'(MAX_RANGES);
    pos_bad   = cnt_t'(pos_q) >= fill;
    // p-1 is the last entry sorting at or before the new range, p the first after
    dup       = (p != '0) & dup_f;
    ovl_fail  = !allow_ovl & (((p != '0) & ovl_prev) | ((p < fill) & ovl_succ));
    shift_end = cnt_t'(k) == p;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_ch.valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (op_q)
          OP_INSERT:  state_next = order_bad ? S_DONE :
                                   (fill == '0) ? S_DECIDE : S_SCAN;
          OP_POINT:   state_next = (fill == '0) ? S_DONE : S_SCAN;
          OP_COVER,
          OP_OVERLAP: state_next = (order_bad | (fill == '0)) ? S_DONE : S_SCAN;
          OP_READ:    state_next = pos_bad ? S_DONE : S_RDENT;
          default:    state_next = S_DONE;
        endcase
      end
      S_SCAN: begin
        if (op_q == OP_INSERT) begin
          if (!not_after || last) state_next = S_DECIDE;
        end else if (q_hit || last) begin
          state_next = S_DONE;
        end
      end
      S_DECIDE: begin
        if (dup || ovl_fail || is_full) state_next = S_DONE;
        else if (p == fill)             state_next = S_PLACE;
        else                            state_next = S_SHIFT;
      end
      S_SHIFT: begin
        if (shift_end) state_next = S_PLACE;
      end
      S_PLACE: state_next = S_DONE;
      S_RDENT: state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready = state == S_IDLE;
    res_valid   = state == S_DONE;
    mem.we      = 1'b0;
    mem.waddr   = '0;
    mem.wdata   = '{lo: a_q, hi: b_q};
    mem.raddr   = '0;
    unique case (state)
      S_DISPATCH: mem.raddr = (op_q == OP_READ) ? pos_q : '0;
      S_SCAN:     mem.raddr = k + ptr_t'(1);
      S_DECIDE:   mem.raddr = ptr_t'(fill - cnt_t'(1));
      S_SHIFT: begin
        // move entry k up one place while fetching k-1
        mem.we    = 1'b1;
        mem.waddr = k + ptr_t'(1);
        mem.wdata = rdata;
        mem.raddr = k - ptr_t'(1);
      end
      S_PLACE: begin
        mem.we    = 1'b1;
        mem.waddr = ptr_t'(p);
      end
      default: ;
    endcase
    res.hit          = res_hit;
    res.slot         = res_slot;
    res.entry_start  = res_es;
    res.entry_end    = res_ee;
    res.status       = res_status;
    res.entries_used = fill;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      allow_ovl <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) allow_ovl <= cfg_data;
      unique case (state)
        S_DISPATCH: begin
          if (op_q == OP_CLEAR) fill <= '0;
        end
        S_PLACE: fill <= fill + cnt_t'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_q  <= in_ch.op;
          a_q   <= in_ch.range_from;
          b_q   <= in_ch.range_to;
          pos_q <= in_ch.position;
        end
      end
      S_DISPATCH: begin
        k          <= '0;
        p          <= '0;
        dup_f      <= 1'b0;
        ovl_prev   <= 1'b0;
        ovl_succ   <= 1'b0;
        res_hit    <= 1'b0;
        res_slot   <= '0;
        res_es     <= '0;
        res_ee     <= '0;
        res_status <= ST_OK;
        if (order_bad && (op_q == OP_INSERT || op_q == OP_COVER ||
                          op_q == OP_OVERLAP)) begin
          res_status <= ST_ORDER;
        end
        if (op_q == OP_READ && pos_bad) res_status <= ST_RANGE;
      end
      S_SCAN: begin
        k <= k + ptr_t'(1);
        if (op_q == OP_INSERT) begin
          if (not_after) begin
            p        <= cnt_t'(k) + cnt_t'(1);
            dup_f    <= rel.s_eq_a & rel.e_eq_b;
            ovl_prev <= rel.e_ge_a;
          end else begin
            ovl_succ <= rel.s_le_b;
          end
        end else if (q_hit) begin
          res_hit <= 1'b1;
        end
      end
      S_DECIDE: begin
        k <= ptr_t'(fill - cnt_t'(1));
        priority if (dup) res_slot   <= ptr_t'(p - cnt_t'(1));
        else if (ovl_fail) res_status <= ST_OVERLAP;
        else if (is_full)  res_status <= ST_FULL;
        else               res_status <= ST_OK;
      end
      S_SHIFT: k <= k - ptr_t'(1);
      S_PLACE: res_slot <= ptr_t'(p);
      S_RDENT: begin
        res_es <= rdata.lo;
        res_ee <= rdata.hi;
      end
      default: ;
    endcase
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= cnt_t'(MAX_RANGES))
    else $error("fill count above table size");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    mem.we |-> (state == S_SHIFT || state == S_PLACE))
    else $error("table write outside shift or place");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(fill) |-> (fill == '0 || fill == $past(fill) + cnt_t'(1)))
    else $error("fill count moved by more than one");

  a_shift_floor: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (cnt_t'(k) >= p))
    else $error("shift went below the insert position");

endmodule

// ----- rtl/core/sorted_range_table.sv -----
// ----------------------------------------------------------------------------
// sorted_range_table
// Table of up to 64 closed ranges kept sorted by start, then end. One request
// at a time; the table sits in a single-port-write memory that is walked one
// entry per cycle. A query stops at its first hit, or at once on an empty
// table (and, for cover and overlap, on a start above end); an insert walks up
// to its slot and then moves the entries above it, unless refused. The result
// goes to the output register, and the sequencer only waits while that
// register still holds an earlier result. The next request is taken while a
// finished result waits in the output register.
// ----------------------------------------------------------------------------
module sorted_range_table import srt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_data,
  srt_in_if.sink     in_ch,
  srt_out_if.source  out_ch
);

  mem_req_t mem;
  entry_t   rdata;
  cmp_t     rel;
  idx_t     a_q;
  idx_t     b_q;
  logic     res_valid;
  res_t     res;
  logic     out_free;
  logic     out_valid;
  res_t     out_q;

  srt_store u_store (
    .clk   (clk),
    .req   (mem),
    .rdata (rdata)
  );

  srt_cmp u_cmp (
    .ent (rdata),
    .a   (a_q),
    .b   (b_q),
    .rel (rel)
  );

  srt_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .mem       (mem),
    .rdata     (rdata),
    .rel       (rel),
    .a_q       (a_q),
    .b_q       (b_q),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free)
  );

  // output register: free when empty or being transferred this cycle
  assign out_free = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      out_q <= res;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.hit          = out_q.hit;
  assign out_ch.slot         = out_q.slot;
  assign out_ch.entry_start  = out_q.entry_start;
  assign out_ch.entry_end    = out_q.entry_end;
  assign out_ch.status       = out_q.status;
  assign out_ch.entries_used = out_q.entries_used;

endmodule
